>>> design/windowed_palette_mode_filter_macros.svh
// Assertion macros shared by the windowed palette mode filter.
`ifndef WINDOWED_PALETTE_MODE_FILTER_MACROS_SVH
`define WINDOWED_PALETTE_MODE_FILTER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication: whenever ante holds, cons holds too.
`define WPMF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication: whenever ante holds, cons holds in the following cycle.
`define WPMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WPMF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define WPMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> design/wpmf_pkg.sv
// Types, constants and codes shared by the palette mode filter files.
`timescale 1ns / 1ps

package wpmf_pkg;

    // Default sizes of the stores and of the window
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int MAX_COLORS_DEF = 16;
    localparam int MAX_RADIUS_DEF = 7;

    // Field widths of the beats
    localparam int OP_W     = 2;
    localparam int COORD_W  = 6;
    localparam int PIX_W    = 32;
    localparam int ENTRY_W  = 4;
    localparam int COLOR_W  = 24;
    localparam int ALPHA_W  = 8;
    localparam int MODE_W   = 4;
    localparam int INDEX_W  = PIX_W - ALPHA_W;

    // Window coordinates carry one more bit than a field: col + radius + 1 can pass 63
    localparam int XY_W = COORD_W + 1;

    // Configuration register widths and reset values
    localparam int FRAME_W    = 7;
    localparam int RADIUS_W   = 3;
    localparam int NCOLOR_W   = 5;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 2;

    localparam logic [FRAME_W-1:0]  FRAME_WIDTH_RST  = 7'd64;
    localparam logic [FRAME_W-1:0]  FRAME_HEIGHT_RST = 7'd64;
    localparam logic [RADIUS_W-1:0] RADIUS_RST       = 3'd1;
    localparam logic [NCOLOR_W-1:0] NCOLOR_RST       = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_PAL_WR = 2'd0,
        OP_PIX_WR = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_WINDOW_RAD   = 2'd2,
        CFG_COLOR_COUNT  = 2'd3
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALPHA,
        S_ALPHA_CAP,
        S_WALK,
        S_DRAIN,
        S_SCAN,
        S_PAL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [FRAME_W-1:0]  frame_width;
        logic [FRAME_W-1:0]  frame_height;
        logic [RADIUS_W-1:0] window_radius;
        logic [NCOLOR_W-1:0] color_count;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   pixel_word;
        logic [ENTRY_W-1:0] entry_index;
        logic [COLOR_W-1:0] entry_color;
    } t_in_beat;

    typedef struct packed {
        logic [PIX_W-1:0]  out_pixel;
        logic [MODE_W-1:0] mode_index;
    } t_result;

    typedef struct packed {
        logic in_rdy;
        logic res_vld;
        logic busy;
    } t_core_sts;

endpackage

>>> design/wpmf_if.sv
// Valid/ready channel interfaces for input beats and result beats.
`timescale 1ns / 1ps

interface wpmf_in_if;
    import wpmf_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [PIX_W-1:0]    pixel_word;
    logic [ENTRY_W-1:0]  entry_index;
    logic [COLOR_W-1:0]  entry_color;

    modport source (
        output valid, op, col, row, pixel_word, entry_index, entry_color,
        input  ready
    );
    modport sink (
        input  valid, op, col, row, pixel_word, entry_index, entry_color,
        output ready
    );
endinterface

interface wpmf_out_if;
    import wpmf_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   out_pixel;
    logic [MODE_W-1:0]  mode_index;

    modport source (output valid, out_pixel, mode_index, input ready);
    modport sink (input valid, out_pixel, mode_index, output ready);
endinterface

>>> design/wpmf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module wpmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> design/wpmf_core.sv
// Query sequencer: image, palette and count memories with the window walk and mode scan.
`timescale 1ns / 1ps

module wpmf_core #(
    parameter int MAX_WIDTH  = wpmf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = wpmf_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_COLORS = wpmf_pkg::MAX_COLORS_DEF,
    parameter int MAX_RADIUS = wpmf_pkg::MAX_RADIUS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wpmf_pkg::t_cfg       i_cfg,
    input  logic                 i_in_vld,
    input  wpmf_pkg::t_in_beat   i_in,
    input  logic                 i_res_rdy,
    output wpmf_pkg::t_result    o_res,
    output wpmf_pkg::t_core_sts  o_sts
);
    import wpmf_pkg::*;

    localparam int IMG_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int IMG_AW    = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
    localparam int CIW       = $clog2(MAX_COLORS);
    localparam int KW        = $clog2(MAX_COLORS + 1);
    localparam int CNT_W     = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);

    t_state r_state, n_state;

    // Query context
    logic [COORD_W-1:0]  r_col, r_row;
    logic [XY_W-1:0]     r_left, r_right, r_down, r_x, r_y;
    logic                r_empty;
    logic                r_alpha_ok;
    logic [ALPHA_W-1:0]  r_alpha;
    logic [KW-1:0]       r_nc;

    // Count pipeline: B = image word back, C = count word back
    logic                r_b_vld, r_c_vld, r_fw_vld;
    logic [CIW-1:0]      r_c_idx, r_fw_idx;
    logic [CNT_W-1:0]    r_fw_val;
    logic [MAX_COLORS-1:0] r_cvalid;

    // Mode scan
    logic [KW-1:0]       r_k;
    logic                r_s_vld;
    logic [CIW-1:0]      r_s_idx;
    logic [CIW-1:0]      r_best;
    logic [CNT_W-1:0]    r_best_cnt;

    // Memory ports
    logic                img_we;
    logic [IMG_AW-1:0]   img_waddr, img_raddr;
    logic [PIX_W-1:0]    img_rdata;
    logic                pal_we;
    logic [CIW-1:0]      pal_waddr;
    logic [COLOR_W-1:0]  pal_rdata;
    logic [CIW-1:0]      cnt_raddr;
    logic [CNT_W-1:0]    cnt_rdata, cnt_old, cnt_new, s_cnt;

    logic                in_acc, q_start, pix_ok, pal_ok;
    logic [XY_W-1:0]     c_ext, r_ext, rad_ext, fw_eff, fh_eff;
    logic [XY_W-1:0]     left, up, right_raw, down_raw, right, down;
    logic [XY_W-1:0]     x_inc, y_inc, rd_x, rd_y;
    logic                walk_row_end, walk_last, scan_more;
    logic [INDEX_W-1:0]  b_idx;
    logic                b_hit;

    // Effective register values and clipped window bounds at query accept
    always_comb begin
        c_ext     = XY_W'(i_in.col);
        r_ext     = XY_W'(i_in.row);
        rad_ext   = (i_cfg.window_radius > MAX_RADIUS) ? XY_W'(MAX_RADIUS)
                                                       : XY_W'(i_cfg.window_radius);
        fw_eff    = (i_cfg.frame_width > MAX_WIDTH) ? XY_W'(MAX_WIDTH)
                                                    : XY_W'(i_cfg.frame_width);
        fh_eff    = (i_cfg.frame_height > MAX_HEIGHT) ? XY_W'(MAX_HEIGHT)
                                                      : XY_W'(i_cfg.frame_height);
        left      = (c_ext > rad_ext) ? c_ext - rad_ext : '0;
        up        = (r_ext > rad_ext) ? r_ext - rad_ext : '0;
        right_raw = c_ext + rad_ext + XY_W'(1);
        down_raw  = r_ext + rad_ext + XY_W'(1);
        right     = (right_raw > fw_eff) ? fw_eff : right_raw;
        down      = (down_raw > fh_eff) ? fh_eff : down_raw;
        pix_ok    = (i_in.col < MAX_WIDTH) && (i_in.row < MAX_HEIGHT);
        pal_ok    = i_in.entry_index < MAX_COLORS;
    end

    assign in_acc  = i_in_vld && (r_state == S_IDLE);
    assign q_start = in_acc && (t_op'(i_in.op) == OP_QUERY);

    // Window walk position
    assign x_inc        = r_x + XY_W'(1);
    assign y_inc        = r_y + XY_W'(1);
    assign walk_row_end = (x_inc == r_right);
    assign walk_last    = walk_row_end && (y_inc == r_down);
    assign scan_more    = (r_k < r_nc);

    // Stage B: palette index from the image word
    assign b_idx = img_rdata[PIX_W-1:ALPHA_W];
    assign b_hit = r_b_vld && (b_idx < r_nc);

    // Stage C: forward the count written in the previous cycle, else an uncleared entry is zero
    always_comb begin
        if (r_fw_vld && (r_fw_idx == r_c_idx)) begin
            cnt_old = r_fw_val;
        end else if (r_cvalid[r_c_idx]) begin
            cnt_old = cnt_rdata;
        end else begin
            cnt_old = '0;
        end
        cnt_new = cnt_old + CNT_W'(1);
        s_cnt   = r_cvalid[r_s_idx] ? cnt_rdata : '0;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (q_start) n_state = S_ALPHA;
            end
            S_ALPHA:     n_state = S_ALPHA_CAP;
            S_ALPHA_CAP: n_state = r_empty ? S_SCAN : S_WALK;
            S_WALK: begin
                if (walk_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!r_b_vld && !r_c_vld) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (!scan_more && !r_s_vld) n_state = S_PAL;
            end
            S_PAL: n_state = S_DONE;
            S_DONE: begin
                if (i_res_rdy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs and memory port control
    always_comb begin
        o_sts.in_rdy  = (r_state == S_IDLE);
        o_sts.res_vld = (r_state == S_DONE);
        o_sts.busy    = (r_state != S_IDLE);
        img_we        = 1'b0;
        pal_we        = 1'b0;
        if (in_acc) begin
            case (t_op'(i_in.op))
                OP_PAL_WR: pal_we = pal_ok;
                OP_PIX_WR: img_we = pix_ok;
                default:   ;
            endcase
        end
        rd_x      = (r_state == S_ALPHA) ? XY_W'(r_col) : r_x;
        rd_y      = (r_state == S_ALPHA) ? XY_W'(r_row) : r_y;
        img_raddr = IMG_AW'(rd_y) * IMG_AW'(MAX_WIDTH) + IMG_AW'(rd_x);
        img_waddr = IMG_AW'(i_in.row) * IMG_AW'(MAX_WIDTH) + IMG_AW'(i_in.col);
        pal_waddr = CIW'(i_in.entry_index);
        cnt_raddr = b_hit ? CIW'(b_idx) : r_k[CIW-1:0];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_b_vld  <= 1'b0;
            r_c_vld  <= 1'b0;
            r_fw_vld <= 1'b0;
            r_s_vld  <= 1'b0;
            r_cvalid <= '0;
        end else begin
            r_state  <= n_state;
            r_b_vld  <= (r_state == S_WALK);
            r_c_vld  <= b_hit;
            r_fw_vld <= r_c_vld;
            r_s_vld  <= (r_state == S_SCAN) && scan_more;
            if (q_start) begin
                r_cvalid <= '0;
            end else if (r_c_vld) begin
                r_cvalid[r_c_idx] <= 1'b1;
            end
        end
    end

    // Query context, walk position and scan datapath
    always_ff @(posedge i_clk) begin
        if (q_start) begin
            r_col      <= i_in.col;
            r_row      <= i_in.row;
            r_left     <= left;
            r_right    <= right;
            r_down     <= down;
            r_x        <= left;
            r_y        <= up;
            r_empty    <= (left >= right) || (up >= down);
            r_alpha_ok <= pix_ok;
            r_nc       <= (i_cfg.color_count > MAX_COLORS) ? KW'(MAX_COLORS)
                                                           : KW'(i_cfg.color_count);
            r_k        <= '0;
            r_best     <= '0;
            r_best_cnt <= '0;
        end
        if (r_state == S_ALPHA_CAP) begin
            r_alpha <= r_alpha_ok ? img_rdata[ALPHA_W-1:0] : '0;
        end
        if (r_state == S_WALK) begin
            if (walk_row_end) begin
                r_x <= r_left;
                r_y <= y_inc;
            end else begin
                r_x <= x_inc;
            end
        end
        r_c_idx  <= CIW'(b_idx);
        r_fw_idx <= r_c_idx;
        r_fw_val <= cnt_new;
        if ((r_state == S_SCAN) && scan_more) begin
            r_s_idx <= r_k[CIW-1:0];
            r_k     <= r_k + KW'(1);
        end
        // Strictly greater keeps the lowest index on a tie
        if (r_s_vld && (s_cnt > r_best_cnt)) begin
            r_best_cnt <= s_cnt;
            r_best     <= r_s_idx;
        end
    end

    // Result: palette color of the mode over the source alpha
    always_comb begin
        o_res.out_pixel  = {pal_rdata, r_alpha};
        o_res.mode_index = MODE_W'(r_best);
    end

    wpmf_ram #(.WIDTH(PIX_W), .DEPTH(IMG_DEPTH)) u_img_ram (
        .i_clk   (i_clk),
        .i_we    (img_we),
        .i_waddr (img_waddr),
        .i_wdata (i_in.pixel_word),
        .i_raddr (img_raddr),
        .o_rdata (img_rdata)
    );

    wpmf_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_COLORS)) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (pal_waddr),
        .i_wdata (i_in.entry_color),
        .i_raddr (r_best),
        .o_rdata (pal_rdata)
    );

    wpmf_ram #(.WIDTH(CNT_W), .DEPTH(MAX_COLORS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (r_c_vld),
        .i_waddr (r_c_idx),
        .i_wdata (cnt_new),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );
endmodule

>>> design/windowed_palette_mode_filter.sv
// Top level: configuration registers, result output register and the query core.
`timescale 1ns / 1ps
`include "windowed_palette_mode_filter_macros.svh"

// Palette mode filter over a stored source image. A palette write or a pixel
// write gives no result. After a query beat is accepted, the S_ALPHA and
// S_ALPHA_CAP states fetch the source alpha, the window walk reads one image
// word per cycle from the single-read-port image memory and pipes it into a
// read-modify-write of the count memory, which S_DRAIN lets empty, the scan
// reads one count per cycle, then the palette entry of the winner is read and
// handed to the output register. An empty window skips the walk and its
// drain. The next beat can be taken in the same cycle as the result shows on
// the output. Input beats are taken only while no query is in progress; a
// finished result sits in an output register, so the next beat can be taken
// while it waits.
module windowed_palette_mode_filter #(
    parameter int MAX_WIDTH  = wpmf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = wpmf_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_COLORS = wpmf_pkg::MAX_COLORS_DEF,
    parameter int MAX_RADIUS = wpmf_pkg::MAX_RADIUS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    wpmf_in_if.sink                            i_in,
    wpmf_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [wpmf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [wpmf_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import wpmf_pkg::*;

    t_cfg      r_cfg;
    t_in_beat  in_beat;
    t_result   core_res;
    t_result   r_out;
    logic      r_out_vld;
    t_core_sts core_sts;
    logic      res_rdy;
    logic      res_load;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width   <= FRAME_WIDTH_RST;
            r_cfg.frame_height  <= FRAME_HEIGHT_RST;
            r_cfg.window_radius <= RADIUS_RST;
            r_cfg.color_count   <= NCOLOR_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_FRAME_WIDTH:  r_cfg.frame_width   <= i_cfg_wdata[FRAME_W-1:0];
                CFG_FRAME_HEIGHT: r_cfg.frame_height  <= i_cfg_wdata[FRAME_W-1:0];
                CFG_WINDOW_RAD:   r_cfg.window_radius <= i_cfg_wdata[RADIUS_W-1:0];
                CFG_COLOR_COUNT:  r_cfg.color_count   <= i_cfg_wdata[NCOLOR_W-1:0];
                default:          ;
            endcase
        end
    end

    // Input beat into the core
    always_comb begin
        in_beat.op          = i_in.op;
        in_beat.col         = i_in.col;
        in_beat.row         = i_in.row;
        in_beat.pixel_word  = i_in.pixel_word;
        in_beat.entry_index = i_in.entry_index;
        in_beat.entry_color = i_in.entry_color;
    end
    assign i_in.ready = core_sts.in_rdy;

    // Output register: loads when empty or being drained this cycle
    assign res_rdy  = !r_out_vld || o_out.ready;
    assign res_load = core_sts.res_vld && res_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= core_res;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.out_pixel  = r_out.out_pixel;
    assign o_out.mode_index = r_out.mode_index;

    wpmf_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_COLORS (MAX_COLORS),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_in_vld  (i_in.valid),
        .i_in      (in_beat),
        .i_res_rdy (res_rdy),
        .o_res     (core_res),
        .o_sts     (core_sts)
    );

    // A stalled core result holds until the output register takes it
    `WPMF_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, core_sts.res_vld && !res_rdy, core_sts.res_vld, "core result dropped while output register full")
    // A result taken from the core shows on the output next cycle
    `WPMF_ASSERT_NEXT(a_res_shown, i_clk, i_rst_n, res_load, o_out.valid, "loaded result not presented")
    // An accepted query keeps the core busy in the following cycle
    `WPMF_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, i_in.valid && i_in.ready && (i_in.op == OP_QUERY), core_sts.busy && !i_in.ready, "query beat did not start the core")
    // The core never offers a result while it takes input beats
    `WPMF_ASSERT_SAME(a_excl, i_clk, i_rst_n, core_sts.res_vld, !i_in.ready, "result offered while idle")
endmodule
